// ----- hw/rtl/gog_pkg.sv -----
// Shared widths, cell codes and the row work item of the glyph outline generator.
`default_nettype none

package gog_pkg;

  localparam int DEF_GLYPH_WIDTH  = 8;
  localparam int DEF_GLYPH_HEIGHT = 8;

  localparam int ROW_W    = 8;                 // glyph row port width
  localparam int CELLS    = 10;                // bordered cells per result beat
  localparam int CELL_W   = 2;                 // bits per cell code
  localparam int CODES_W  = CELLS * CELL_W;    // 20
  localparam int ROWNUM_W = 4;

  localparam logic [CELL_W-1:0] CODE_EMPTY  = 2'd0;
  localparam logic [CELL_W-1:0] CODE_GLYPH  = 2'd1;
  localparam logic [CELL_W-1:0] CODE_BORDER = 2'd2;

  // One accepted glyph row together with the history it is coded against.
  typedef struct packed {
    logic [ROW_W-1:0]    upper;    // two rows up
    logic [ROW_W-1:0]    center;   // previous row
    logic [ROW_W-1:0]    lower;    // the row just accepted
    logic [ROWNUM_W-1:0] row_num;  // bordered row index of the first beat
    logic                last;     // last glyph row: three beats
  } work_item_t;

  // Pixel columns inside the glyph width.
  function automatic logic [ROW_W-1:0] row_mask(input int width);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i < width);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/glyph_outline_generator.sv -----
// Top level of the glyph outline generator: work stage, beat sequencing, output register.
`default_nettype none

// Glyph outline generator. Feed a glyph one row per beat on in_glyph_row,
// top row first, GLYPH_HEIGHT rows per glyph; bit c is pixel column c and
// columns at or beyond GLYPH_WIDTH are ignored. Every row yields one
// bordered row on the out_ channel, GLYPH_WIDTH+2 cells of 2 bits (cell 0 in
// the low bits): 1 where the pixel is set, 2 where any pixel of its 3x3
// neighborhood is set, 0 otherwise. The last glyph row yields three beats
// (the last two glyph-bordered rows and the bottom border row), the final
// one flagged with out_glyph_done; row numbering then restarts at 0 for
// the next glyph. Rate: one input beat per clock unless out_stall holds
// the output, for every row but the last, which holds the input while its
// remaining beats leave the single work stage. From input accept, a row
// passes the work register, then the output register, before its first
// output beat; the output register lets the work stage refill while a
// beat waits on out_stall.
module glyph_outline_generator #(
  parameter int GLYPH_WIDTH  = gog_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = gog_pkg::DEF_GLYPH_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [gog_pkg::ROW_W-1:0]    in_glyph_row,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [gog_pkg::CODES_W-1:0]  out_cell_codes,
  output logic      [gog_pkg::ROWNUM_W-1:0] out_row_number,
  output logic                              out_glyph_done
);
  import gog_pkg::*;

  // which bordered row of the current item is being emitted
  typedef enum logic [1:0] {PH_ROW, PH_BELOW, PH_BOTTOM} phase_t;

  work_item_t            trk_item;
  work_item_t            work_r,    work_nxt;
  logic                  work_v_r,  work_v_nxt;
  phase_t                phase_r,   phase_nxt;
  logic                  out_v_r,   out_v_nxt;
  logic [CODES_W-1:0]    codes_r;
  logic [ROWNUM_W-1:0]   rownum_r;
  logic                  done_r;

  logic                  in_acc;
  logic                  out_ld_ok;
  logic                  work_fire;
  logic                  work_final;
  logic [ROW_W-1:0]      sel_upper, sel_center, sel_lower;
  logic [CODES_W-1:0]    beat_codes;
  logic [ROWNUM_W-1:0]   beat_rownum;
  logic                  beat_done;

  gog_row_track #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_acc   (in_acc),
    .glyph_row (in_glyph_row),
    .item      (trk_item)
  );

  // handshake: output register frees when empty or being taken
  assign out_ld_ok  = !out_v_r || !out_stall;
  assign work_fire  = work_v_r && out_ld_ok;
  assign work_final = (phase_r == PH_BOTTOM) || !work_r.last;
  assign in_stall   = work_v_r && !(work_fire && work_final);
  assign in_acc     = in_valid && !in_stall;

  // row window slides down one row per extra beat, zeros below the glyph
  always_comb begin
    case (phase_r)
      PH_ROW: begin
        sel_upper  = work_r.upper;
        sel_center = work_r.center;
        sel_lower  = work_r.lower;
      end
      PH_BELOW: begin
        sel_upper  = work_r.center;
        sel_center = work_r.lower;
        sel_lower  = '0;
      end
      PH_BOTTOM: begin
        sel_upper  = work_r.lower;
        sel_center = '0;
        sel_lower  = '0;
      end
      default: begin
        sel_upper  = '0;
        sel_center = '0;
        sel_lower  = '0;
      end
    endcase
  end

  gog_row_coder u_coder (
    .upper  (sel_upper),
    .center (sel_center),
    .lower  (sel_lower),
    .codes  (beat_codes)
  );

  assign beat_rownum = work_r.row_num + ROWNUM_W'(phase_r);
  assign beat_done   = work_r.last && (phase_r == PH_BOTTOM);

  always_comb begin
    work_nxt   = work_r;
    work_v_nxt = work_v_r;
    phase_nxt  = phase_r;
    if (work_fire) begin
      case (phase_r)
        PH_ROW:    phase_nxt = PH_BELOW;
        PH_BELOW:  phase_nxt = PH_BOTTOM;
        default:   phase_nxt = PH_ROW;
      endcase
      if (work_final) begin
        work_v_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      work_nxt   = trk_item;
      work_v_nxt = 1'b1;
      phase_nxt  = PH_ROW;
    end
    out_v_nxt = work_fire || (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      phase_r  <= PH_ROW;
      out_v_r  <= 1'b0;
    end else begin
      work_v_r <= work_v_nxt;
      phase_r  <= phase_nxt;
      out_v_r  <= out_v_nxt;
    end
    work_r <= work_nxt;
    if (work_fire) begin
      codes_r  <= beat_codes;
      rownum_r <= beat_rownum;
      done_r   <= beat_done;
    end
  end

  assign out_valid      = out_v_r;
  assign out_cell_codes = codes_r;
  assign out_row_number = rownum_r;
  assign out_glyph_done = done_r;

  // the glyph-done beat is always the bottom border row
  a_done_rownum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && done_r) |-> (rownum_r == ROWNUM_W'(GLYPH_HEIGHT + 1)))
    else $error("glyph done beat carries wrong row number");

  // a freshly accepted row starts at its first beat
  a_accept_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (work_v_r && (phase_r == PH_ROW)))
    else $error("accepted row did not enter work stage at first beat");

  // extra beats belong only to the last glyph row
  a_extra_last: assert property (@(posedge clk) disable iff (!rst_n)
    (work_v_r && (phase_r != PH_ROW)) |-> work_r.last)
    else $error("extra beat on a row that is not the last");

  // an unfinished item stays in the work stage
  a_hold_work: assert property (@(posedge clk) disable iff (!rst_n)
    (work_v_r && !(work_fire && work_final)) |-> in_stall)
    else $error("input taken while work stage busy");

endmodule

`default_nettype wire

// ----- hw/rtl/gog_row_coder.sv -----
// Codes one bordered row from three neighboring glyph rows (3x3 dilation).
`default_nettype none

module gog_row_coder (
  input  wire logic [gog_pkg::ROW_W-1:0]   upper,
  input  wire logic [gog_pkg::ROW_W-1:0]   center,
  input  wire logic [gog_pkg::ROW_W-1:0]   lower,
  output logic      [gog_pkg::CODES_W-1:0] codes
);
  import gog_pkg::*;

  logic [CELLS-1:0] any_ext;
  logic [CELLS-1:0] near;
  logic [CELLS-1:0] self_px;

  // Bordered cell c sits on pixel c-1; its neighborhood spans pixels c-2..c.
  assign any_ext = {{(CELLS-ROW_W){1'b0}}, (upper | center | lower)};
  assign near    = any_ext | (any_ext << 1) | (any_ext << 2);
  assign self_px = {{(CELLS-ROW_W-1){1'b0}}, center, 1'b0};

  always_comb begin
    for (int c = 0; c < CELLS; c++) begin
      if (self_px[c]) begin
        codes[c*CELL_W +: CELL_W] = CODE_GLYPH;
      end else if (near[c]) begin
        codes[c*CELL_W +: CELL_W] = CODE_BORDER;
      end else begin
        codes[c*CELL_W +: CELL_W] = CODE_EMPTY;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gog_row_track.sv -----
// Row history and row counter; builds the work item for each accepted glyph row.
`default_nettype none

module gog_row_track #(
  parameter int GLYPH_WIDTH  = gog_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = gog_pkg::DEF_GLYPH_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      row_acc,
  input  wire logic [gog_pkg::ROW_W-1:0] glyph_row,
  output gog_pkg::work_item_t            item
);
  import gog_pkg::*;

  localparam int CNT_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GLYPH_HEIGHT - 1);
  localparam logic [ROW_W-1:0] COL_MASK = row_mask(GLYPH_WIDTH);

  logic [ROW_W-1:0] above_r,     above_nxt;
  logic [ROW_W-1:0] two_above_r, two_above_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic [ROW_W-1:0] row_in;
  logic             last_row;

  assign row_in   = glyph_row & COL_MASK;
  assign last_row = (cnt_r == LAST_ROW);

  assign item.upper   = two_above_r;
  assign item.center  = above_r;
  assign item.lower   = row_in;
  assign item.row_num = ROWNUM_W'(cnt_r);
  assign item.last    = last_row;

  always_comb begin
    above_nxt     = above_r;
    two_above_nxt = two_above_r;
    cnt_nxt       = cnt_r;
    if (row_acc) begin
      if (last_row) begin
        // glyph complete: next beat starts a fresh glyph
        above_nxt     = '0;
        two_above_nxt = '0;
        cnt_nxt       = '0;
      end else begin
        above_nxt     = row_in;
        two_above_nxt = above_r;
        cnt_nxt       = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= '0;
      two_above_r <= '0;
      cnt_r       <= '0;
    end else begin
      above_r     <= above_nxt;
      two_above_r <= two_above_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_glyph_outline_generator.sv -----
// Self-checking testbench for the glyph outline generator (3x3 dilation outline).
`timescale 1ns / 100ps

// How the test works:
//  - Glyph rows are sent one beat at a time on the in_ channel. Every accepted
//    row goes through a local outline predictor, which queues the bordered rows
//    it should produce: one per row, and three for the last row of a glyph.
//  - A monitor pops the oldest queued bordered row for each out_ beat and
//    compares codes, row number and done flag separately.
//  - Directed glyphs come first: blank and full rows, the edge columns, lone
//    corner pixels, a solid glyph. After them come random glyphs with a mix of
//    sparse, dense and fully random rows. The last few glyphs run with no
//    idling on either side.
//  - The sender leaves random gaps between rows. The receiver stalls in
//    random bursts.
module tb_glyph_outline_generator;
  import gog_pkg::*;

  localparam int GW = DEF_GLYPH_WIDTH;
  localparam int GH = DEF_GLYPH_HEIGHT;
  localparam logic [ROW_W-1:0] GLYPH_MASK =
    (GW >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << GW) - 1);

  // One expected bordered row, laid out like the out_ channel.
  typedef struct packed {
    logic [CODES_W-1:0]  codes;
    logic [ROWNUM_W-1:0] row_num;
    logic                done;
  } bordered_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ROW_W-1:0] in_glyph_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODES_W-1:0] out_cell_codes;
  logic [ROWNUM_W-1:0] out_row_number;
  logic out_glyph_done;

  glyph_outline_generator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_glyph_row   (in_glyph_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_codes (out_cell_codes),
    .out_row_number (out_row_number),
    .out_glyph_done (out_glyph_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop. The slowest legal run of about 270 rows, with every gap and
  // stall at its longest, ends well before it.
  initial begin
    #200000;
    $display("glyph_outline_generator regression: fail");
    $finish;
  end

  // Predictor state: the two glyph rows above the next one, and the index of
  // the next glyph row within its glyph.
  logic [ROW_W-1:0] glyph_prev  = '0;
  logic [ROW_W-1:0] glyph_prev2 = '0;
  int unsigned      rows_in_glyph = 0;

  bordered_row_t expected_rows[$];
  int unsigned   mismatches = 0;

  // Idling controls. steady turns off both gaps and stalls.
  bit          steady = 1'b0;
  int unsigned gap_odds = 4;     // a gap before roughly 1 in gap_odds rows
  int unsigned stall_left = 0;

  // Codes one bordered row. center is the glyph row that lies under it;
  // upper and lower are the glyph rows next to it. Bordered cell c stands
  // over pixel column c-1.
  function automatic logic [CODES_W-1:0] outline_codes(input logic [ROW_W-1:0] upper,
                                                       input logic [ROW_W-1:0] center,
                                                       input logic [ROW_W-1:0] lower);
    logic [CELLS-1:0]   lit;
    logic [CELLS-1:0]   halo;
    logic [CELLS-1:0]   own;
    logic [CODES_W-1:0] codes;
    lit   = CELLS'(upper | center | lower);
    halo  = lit | (lit << 1) | (lit << 2);
    own   = CELLS'(center) << 1;
    codes = '0;
    for (int c = 0; c < CELLS; c++) begin
      if (c >= GW + 2)
        codes[c*CELL_W +: CELL_W] = CODE_EMPTY;
      else if (own[c])
        codes[c*CELL_W +: CELL_W] = CODE_GLYPH;
      else if (halo[c])
        codes[c*CELL_W +: CELL_W] = CODE_BORDER;
      else
        codes[c*CELL_W +: CELL_W] = CODE_EMPTY;
    end
    return codes;
  endfunction

  function automatic bordered_row_t make_row(input logic [CODES_W-1:0] codes,
                                             input int unsigned num, input bit done);
    bordered_row_t r;
    r.codes   = codes;
    r.row_num = num[ROWNUM_W-1:0];
    r.done    = done;
    return r;
  endfunction

  // Queue the bordered rows that one accepted glyph row yields.
  task automatic predict_outline(input logic [ROW_W-1:0] raw);
    logic [ROW_W-1:0] px;
    px = raw & GLYPH_MASK;
    expected_rows.push_back(make_row(outline_codes(glyph_prev2, glyph_prev, px),
                                     rows_in_glyph, 1'b0));
    if (rows_in_glyph + 1 >= GH) begin
      // Last glyph row: it is flushed together with the bottom border row,
      // and the next beat starts a fresh glyph.
      expected_rows.push_back(make_row(outline_codes(glyph_prev, px, '0),
                                       rows_in_glyph + 1, 1'b0));
      expected_rows.push_back(make_row(outline_codes(px, '0, '0),
                                       rows_in_glyph + 2, 1'b1));
      glyph_prev    = '0;
      glyph_prev2   = '0;
      rows_in_glyph = 0;
    end else begin
      glyph_prev2   = glyph_prev;
      glyph_prev    = px;
      rows_in_glyph = rows_in_glyph + 1;
    end
  endtask

  // Send one row beat. The task is entered and left just after a falling
  // edge. valid stays high into the next row unless a gap is taken.
  task automatic send_row(input logic [ROW_W-1:0] row);
    if (!steady && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_glyph_row = row;
    do @(posedge clk); while (in_stall);
    predict_outline(row);
    @(negedge clk);
  endtask

  task automatic send_glyph(input logic [ROW_W-1:0] rows[GH]);
    for (int r = 0; r < GH; r++) send_row(rows[r]);
  endtask

  // Random row in one of several styles, so that outlines run from sparse
  // specks to nearly solid blocks.
  function automatic logic [ROW_W-1:0] random_glyph_row();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
      2:       return ROW_W'($urandom) | ROW_W'($urandom);
      3:       return ROW_W'($urandom) & ROW_W'($urandom);
      default: return ROW_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // Blank and full rows, the edge columns alone and together, two alternating
  // patterns. A blank row comes first, so the top border row stays empty.
  task automatic test_mixed_rows();
    logic [ROW_W-1:0] g[GH];
    g = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h81, 8'h55, 8'hAA};
    send_glyph(g);
  endtask

  // Lone pixels in the top-left and bottom-right corners. Their halos spill
  // into the border rows and columns on both sides.
  task automatic test_corner_pixels();
    logic [ROW_W-1:0] g[GH];
    g = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
    send_glyph(g);
  endtask

  // Every pixel set: only the outer ring of cells is border.
  task automatic test_solid_glyph();
    logic [ROW_W-1:0] g[GH];
    for (int r = 0; r < GH; r++) g[r] = '1;
    send_glyph(g);
  endtask

  // Random glyphs, back to back. The sender's gap rate changes per glyph, so
  // some glyphs go through with almost no gaps.
  task automatic test_random_glyphs(input int unsigned n_glyphs);
    logic [ROW_W-1:0] g[GH];
    for (int k = 0; k < n_glyphs; k++) begin
      gap_odds = $urandom_range(2, 12);
      for (int r = 0; r < GH; r++) g[r] = random_glyph_row();
      send_glyph(g);
    end
  endtask

  // Closing stretch at full rate: no gaps and no stalls.
  task automatic test_full_rate(input int unsigned n_glyphs);
    steady = 1'b1;
    test_random_glyphs(n_glyphs);
  endtask

  // --------------------------------------------------------- stall driver

  always @(negedge clk) begin
    if (!rst_n || steady) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------- checker

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    bordered_row_t exp_row;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        note_mismatch("unexpected beat, row", 32'hFFFF_FFFF, 32'(out_row_number));
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_cell_codes !== exp_row.codes)
          note_mismatch("cell_codes", 32'(exp_row.codes), 32'(out_cell_codes));
        if (out_row_number !== exp_row.row_num)
          note_mismatch("row_number", 32'(exp_row.row_num), 32'(out_row_number));
        if (out_glyph_done !== exp_row.done)
          note_mismatch("glyph_done", 32'(exp_row.done), 32'(out_glyph_done));
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_mixed_rows();
    test_corner_pixels();
    test_solid_glyph();
    test_random_glyphs(28);
    test_full_rate(3);

    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then give the two-stage pipe time to show any extra beat.
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_rows.size() == 0)
      $display("glyph_outline_generator regression: pass");
    else
      $display("glyph_outline_generator regression: fail");
    $finish;
  end

endmodule
